### rtl/deq_pkg.sv
// Shared request and status codes and default sizing for the double-ended queue.
`default_nettype none

package deq_pkg;

	// Default number of entries in the ring store.
	localparam int DEQ_DEPTH = 16;

	// Field widths fixed by the interface.
	localparam int REQ_W    = 2;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

### rtl/double_ended_queue_top.sv
// Top level of the double-ended queue: ring pointers, result pipeline and output register.
//
// Usage:
//   Requests enter on the input channel (in_valid/in_ready) with req_type and
//   push_value. Every request yields exactly one result item on the output
//   channel (out_valid/out_ready) carrying pop_value, status and entry_count.
//   The front pointer and entry count are updated at the edge that accepts a
//   request; a push writes the memory and a pop reads it at that same edge.
//   The read data is held in the read stage and moves into the output register
//   when that register is free, which raises out_valid. The block takes one
//   request per cycle while the receiver does not stall; the single-port entry
//   memory with its registered read sets that rate.
//   A request holds pointers and memory only for its own accept edge, so
//   back-to-back requests need no forwarding.
//   When the receiver stalls, the output register holds its item and one more
//   result waits in the read stage; then in_ready drops until out_ready rises.
//   Reset empties the queue (front pointer and count to zero) and clears both
//   valid flags; the memory contents are not cleared and are never read
//   before they are written.
`default_nettype none

module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [REQ_W-1:0]    req_type,
	input  wire logic [DATA_W-1:0]   push_value,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic      [DATA_W-1:0]   pop_value,
	output logic      [STATUS_W-1:0] status,
	output logic      [COUNT_W-1:0]  entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;

	logic          in_fire;
	logic          is_full;
	logic          is_empty;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [SW-1:0] back_sum;
	logic [SW-1:0] back_wrap;
	logic [SW-1:0] last_wrap;

	logic                mem_wr;
	logic                mem_rd;
	logic [AW-1:0]       mem_addr;
	logic [DATA_W-1:0]   mem_rdata;
	logic [AW-1:0]       front_nxt;
	logic [CW-1:0]       count_nxt;
	logic [STATUS_W-1:0] status_nxt;
	logic                pop_ok_nxt;

	logic                valid_s1;
	logic                pop_ok_s1;
	logic [STATUS_W-1:0] status_s1;
	logic [CW-1:0]       count_s1;
	logic                advance_s1;

	logic                out_valid_q;
	logic [DATA_W-1:0]   pop_value_q;
	logic [STATUS_W-1:0] status_q;
	logic [CW-1:0]       out_count_q;
	logic [CW+COUNT_W-1:0] count_ext;

	// Handshake: the read stage moves on when the output register is free.
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;
	assign in_fire    = in_valid && in_ready;

	// Ring positions, each wrapping modulo DEPTH with a single compare.
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign back_sum  = SW'(front_q) + SW'(count_q);
	assign back_wrap = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
	assign last_wrap = (back_wrap == '0) ? SW'(DEPTH - 1) : back_wrap - SW'(1);

	// Request decode: memory access, pointer update and status.
	always_comb begin
		mem_wr     = 1'b0;
		mem_rd     = 1'b0;
		mem_addr   = front_q;
		front_nxt  = front_q;
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		pop_ok_nxt = 1'b0;
		unique case (req_type)
			REQ_PUSH_FRONT: begin
				if (is_full) begin
					status_nxt = ST_FULL;
				end else begin
					mem_wr    = 1'b1;
					mem_addr  = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + CW'(1);
				end
			end
			REQ_PUSH_BACK: begin
				if (is_full) begin
					status_nxt = ST_FULL;
				end else begin
					mem_wr    = 1'b1;
					mem_addr  = back_wrap[AW-1:0];
					count_nxt = count_q + CW'(1);
				end
			end
			REQ_POP_FRONT: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					mem_rd     = 1'b1;
					pop_ok_nxt = 1'b1;
					mem_addr   = front_q;
					front_nxt  = front_inc;
					count_nxt  = count_q - CW'(1);
				end
			end
			REQ_POP_BACK: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					mem_rd     = 1'b1;
					pop_ok_nxt = 1'b1;
					mem_addr   = last_wrap[AW-1:0];
					count_nxt  = count_q - CW'(1);
				end
			end
			default: begin
				status_nxt = ST_DONE;
			end
		endcase
	end

	deq_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.wr_en (mem_wr && in_fire),
		.rd_en (mem_rd && in_fire),
		.addr  (mem_addr),
		.wdata (push_value),
		.rdata (mem_rdata)
	);

	// Ring pointer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (in_fire) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// Read stage: waits for the memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pop_ok_s1 <= pop_ok_nxt;
			status_s1 <= status_nxt;
			count_s1  <= count_nxt;
		end
	end

	// Output register: holds the result item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			pop_value_q <= pop_ok_s1 ? mem_rdata : '0;
			status_q    <= status_s1;
			out_count_q <= count_s1;
		end
	end

	// The reported count is the held count, zero-extended and then truncated to the field width.
	assign count_ext   = {{COUNT_W{1'b0}}, out_count_q};
	assign out_valid   = out_valid_q;
	assign pop_value   = pop_value_q;
	assign status      = status_q;
	assign entry_count = count_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

### rtl/deq_store.sv
// Single-port entry memory with a registered read port.
`default_nettype none

module deq_store
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [DATA_W-1:0]        wdata,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// Write on a push, read on a pop; at most one of them per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/deq_checker.sv
// Port-level checks on the double-ended queue, bound to its top level.
`default_nettype none

module deq_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [DATA_W-1:0]   pop_value,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [COUNT_W-1:0]  entry_count
);

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

	// A stalled result item keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status)
			&& $stable(entry_count))
		else $error("result item changed while stalled");

	// A refused push reports a full queue and returns no value.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == FULL_COUNT && pop_value == '0)
		else $error("push on full queue reported wrong count or value");

	// A refused pop reports an empty queue and returns no value.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> entry_count == '0 && pop_value == '0)
		else $error("pop on empty queue reported wrong count or value");

	// No result item appears unless a request was accepted and moved through the read stage.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result item without a request");

endmodule

bind double_ended_queue_top deq_checker #(
	.DEPTH (DEPTH)
) u_deq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pop_value   (pop_value),
	.status      (status),
	.entry_count (entry_count)
);

`default_nettype wire
